>>> rtl/mtp_pkg.sv
// ----------------------------------------------------------------------------
// Motor thrust PWM converter package
// Shared constants, register indexes and item types for the converter.
// ----------------------------------------------------------------------------
package mtp_pkg;

   localparam int PWM_BITS  = 8;
   localparam int COEF_W    = 32;
   localparam int THR_W     = 24;
   localparam int MAXT_W    = 23;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;

   localparam logic [PWM_BITS-1:0] PWM_MAX = {PWM_BITS{1'b1}};

   localparam logic [CSR_IDX_W-1:0] REG_QUAD_FWD   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIN_FWD    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_FWD = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_QUAD_REV   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LIN_REV    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_REV = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAXT_FWD   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MAXT_REV   = 4'd7;

   localparam int DIFF_W    = THR_W + 13;
   localparam int SQ_D_W    = 72;
   localparam int SQ_ROOT_W = SQ_D_W / 2;
   localparam int SQ_REM_W  = SQ_ROOT_W + 4;
   localparam int NUM_W     = SQ_ROOT_W + 2;
   localparam int DEN_W     = COEF_W + 1;
   localparam int DIV_REM_W = DEN_W + PWM_BITS + 1;

   typedef struct packed {
      logic                    mode;
      logic                    direction;
      logic [PWM_BITS-1:0]     pwm_in;
      logic signed [THR_W-1:0] thrust_in;
   } req_type;

   typedef struct packed {
      logic signed [THR_W-1:0] thrust_out;
      logic [PWM_BITS-1:0]     pwm_out;
      logic                    domain_error;
   } rsp_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
      logic [MAXT_W-1:0]        tmax;
   } coef_type;

   typedef struct packed {
      logic                     valid;
      logic                     mode;
      logic                     done;
      logic signed [THR_W-1:0]  thrust;
      logic [PWM_BITS-1:0]      pwm;
      logic                     err;
      logic                     a_pos;
      logic [COEF_W-1:0]        mag_a;
      logic signed [COEF_W-1:0] b;
   } tok_type;

   typedef struct packed {
      logic [SQ_REM_W-1:0]  rem;
      logic [SQ_ROOT_W-1:0] root;
      logic [SQ_D_W-1:0]    dsh;
   } sq_type;

   typedef struct packed {
      logic [DIV_REM_W-1:0] rem;
      logic [PWM_BITS-1:0]  quo;
   } dv_type;

endpackage

>>> rtl/mtp_front.sv
// ----------------------------------------------------------------------------
// Converter front end
// Selects the curve, evaluates the forward polynomial and forms the
// discriminant of the inverse over four pipeline stages.
// ----------------------------------------------------------------------------
module mtp_front
   import mtp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  req_type           req,
   input  coef_type          coef_fwd,
   input  coef_type          coef_rev,
   output tok_type           tok_out,
   output logic [SQ_D_W-1:0] disc_out
);

   coef_type                 sel;
   logic signed [PWM_BITS:0] p9;
   logic signed [DIFF_W-1:0] diff;
   logic [COEF_W-1:0]        mag_b;
   tok_type                  tok1_in;

   tok_type                          tok1_ff;
   logic [PWM_BITS-1:0]              p1_ff;
   logic signed [COEF_W+PWM_BITS:0]  ap1_ff;
   logic signed [COEF_W+PWM_BITS:0]  bp1_ff;
   logic signed [COEF_W-1:0]         c1_ff;
   logic [DIFF_W-1:0]                magd1_ff;
   logic                             pneg1_ff;
   logic [2*COEF_W-1:0]              b2_1_ff;

   tok_type                            tok2_ff;
   logic [PWM_BITS-1:0]                p2_ff;
   logic signed [COEF_W+2*PWM_BITS+1:0] app2_ff;
   logic signed [COEF_W+PWM_BITS:0]    bp2_ff;
   logic signed [COEF_W-1:0]           c2_ff;
   logic [2*COEF_W-1:0]                palo2_ff;
   logic [COEF_W+DIFF_W-33:0]          pahi2_ff;
   logic                               pneg2_ff;
   logic [2*COEF_W-1:0]                b2_2_ff;

   logic signed [COEF_W+2*PWM_BITS+1:0] sum3;
   logic signed [COEF_W+2*PWM_BITS+1:0] q3;
   tok_type                             tok3_in;
   tok_type                             tok3_ff;
   logic [SQ_D_W-1:0]                   p4_3_ff;
   logic                                pneg3_ff;
   logic [2*COEF_W-1:0]                 b2_3_ff;

   logic [SQ_D_W-1:0] b2_ext;
   tok_type           tok4_in;
   logic [SQ_D_W-1:0] disc4_in;
   tok_type           tok4_ff;
   logic [SQ_D_W-1:0] disc4_ff;

   always_comb begin
      sel   = req.direction ? coef_fwd : coef_rev;
      p9    = $signed({1'b0, req.pwm_in});
      diff  = $signed({req.thrust_in[THR_W-1], req.thrust_in, 12'b0})
            - DIFF_W'(sel.c);
      mag_b = sel.b[COEF_W-1] ? COEF_W'(-sel.b) : sel.b;
      tok1_in        = '0;
      tok1_in.valid  = in_valid;
      tok1_in.mode   = req.mode;
      tok1_in.a_pos  = !sel.a[COEF_W-1];
      tok1_in.mag_a  = sel.a[COEF_W-1] ? COEF_W'(-sel.a) : sel.a;
      tok1_in.b      = sel.b;
      if (req.mode) begin
         if (req.thrust_in <= 0) begin
            tok1_in.done = 1'b1;
         end else if (req.thrust_in >= $signed({1'b0, sel.tmax})) begin
            tok1_in.done = 1'b1;
            tok1_in.pwm  = PWM_MAX;
         end else if (sel.a == '0) begin
            tok1_in.done = 1'b1;
            tok1_in.err  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok1_ff.valid <= 1'b0;
         tok2_ff.valid <= 1'b0;
         tok3_ff.valid <= 1'b0;
         tok4_ff.valid <= 1'b0;
      end else if (advance) begin
         tok1_ff  <= tok1_in;
         p1_ff    <= req.pwm_in;
         ap1_ff   <= sel.a * p9;
         bp1_ff   <= sel.b * p9;
         c1_ff    <= sel.c;
         magd1_ff <= diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
         pneg1_ff <= (diff != '0) && (sel.a[COEF_W-1] != diff[DIFF_W-1]);
         b2_1_ff  <= mag_b * mag_b;

         tok2_ff  <= tok1_ff;
         p2_ff    <= p1_ff;
         app2_ff  <= ap1_ff * $signed({1'b0, p1_ff});
         bp2_ff   <= bp1_ff;
         c2_ff    <= c1_ff;
         palo2_ff <= tok1_ff.mag_a * magd1_ff[31:0];
         pahi2_ff <= tok1_ff.mag_a * magd1_ff[DIFF_W-1:32];
         pneg2_ff <= pneg1_ff;
         b2_2_ff  <= b2_1_ff;

         tok3_ff  <= tok3_in;
         p4_3_ff  <= (SQ_D_W'({pahi2_ff, 32'b0}) + SQ_D_W'(palo2_ff)) << 2;
         pneg3_ff <= pneg2_ff;
         b2_3_ff  <= b2_2_ff;

         tok4_ff  <= tok4_in;
         disc4_ff <= disc4_in;
      end
   end

   always_comb begin
      sum3    = app2_ff + bp2_ff + c2_ff;
      q3      = sum3 >>> 12;
      tok3_in = tok2_ff;
      if (!tok2_ff.mode) begin
         tok3_in.done = 1'b1;
         if (p2_ff == '0) begin
            tok3_in.thrust = '0;
         end else if (q3 > (2 ** (THR_W - 1)) - 1) begin
            tok3_in.thrust = {1'b0, {(THR_W-1){1'b1}}};
         end else if (q3 < -(2 ** (THR_W - 1))) begin
            tok3_in.thrust = {1'b1, {(THR_W-1){1'b0}}};
         end else begin
            tok3_in.thrust = q3[THR_W-1:0];
         end
      end
   end

   always_comb begin
      b2_ext   = SQ_D_W'(b2_3_ff);
      tok4_in  = tok3_ff;
      disc4_in = '0;
      if (!pneg3_ff) begin
         disc4_in = p4_3_ff + b2_ext;
      end else if (p4_3_ff > b2_ext) begin
         if (!tok3_ff.done) begin
            tok4_in.done = 1'b1;
            tok4_in.err  = 1'b1;
         end
      end else begin
         disc4_in = b2_ext - p4_3_ff;
      end
   end

   assign tok_out  = tok4_ff;
   assign disc_out = disc4_ff;

endmodule

>>> rtl/mtp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// Settles one root bit from the next two discriminant bits.
// ----------------------------------------------------------------------------
module mtp_sqrt_cell
   import mtp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  tok_type tok_in,
   input  sq_type  sq_in,
   output tok_type tok_out,
   output sq_type  sq_out
);

   logic [SQ_REM_W-1:0] rem_sh;
   logic [SQ_REM_W-1:0] trial;
   logic                ge;
   sq_type              sq_nx_in;
   tok_type             tok_ff;
   sq_type              sq_ff;

   always_comb begin
      rem_sh = {sq_in.rem[SQ_REM_W-3:0], sq_in.dsh[SQ_D_W-1:SQ_D_W-2]};
      trial  = SQ_REM_W'({sq_in.root, 2'b01});
      ge     = rem_sh >= trial;
      sq_nx_in.rem  = ge ? rem_sh - trial : rem_sh;
      sq_nx_in.root = {sq_in.root[SQ_ROOT_W-2:0], ge};
      sq_nx_in.dsh  = sq_in.dsh << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
         sq_ff  <= sq_nx_in;
      end
   end

   assign tok_out = tok_ff;
   assign sq_out  = sq_ff;

endmodule

>>> rtl/mtp_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// Settles one quotient bit of the root numerator over twice the magnitude of the quadratic coefficient.
// ----------------------------------------------------------------------------
module mtp_div_cell
   import mtp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  tok_type tok_in,
   input  dv_type  dv_in,
   output tok_type tok_out,
   output dv_type  dv_out
);

   logic [DIV_REM_W-1:0] den_sh;
   logic                 ge;
   dv_type               dv_nx_in;
   tok_type              tok_ff;
   dv_type               dv_ff;

   always_comb begin
      den_sh = DIV_REM_W'({tok_in.mag_a, 1'b0}) << (PWM_BITS - 1);
      ge     = dv_in.rem >= den_sh;
      dv_nx_in.rem = (ge ? dv_in.rem - den_sh : dv_in.rem) << 1;
      dv_nx_in.quo = {dv_in.quo[PWM_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
         dv_ff  <= dv_nx_in;
      end
   end

   assign tok_out = tok_ff;
   assign dv_out  = dv_ff;

endmodule

>>> rtl/motor_thrust_pwm_converter_top.sv
// ----------------------------------------------------------------------------
// Motor thrust PWM converter
// Quadratic thrust curve per direction and its inverse, fully pipelined.
//
//   Port group  Flow   Handshake         Contents
//   req_        in     valid / stall     mode, direction, pwm_in, thrust_in
//   rsp_        out    valid / stall     thrust_out, pwm_out, domain_error
//   csr_        in     valid / ready     register index and write data
//
// One item is taken in every cycle while the output does not stall; each result passes through
// four front stages, one root cell per root bit (36), two numerator
// stages, one divider cell per PWM bit and the output register.
// Reset is synchronous and clears the coefficients and all valid flags.
// A stalled output holds the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
module motor_thrust_pwm_converter_top
   import mtp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   coef_type coef_fwd_ff;
   coef_type coef_rev_ff;
   logic     advance;

   tok_type           front_tok;
   logic [SQ_D_W-1:0] front_disc;

   tok_type sq_tok [0:SQ_ROOT_W];
   sq_type  sq_dat [0:SQ_ROOT_W];

   logic signed [NUM_W-1:0] n_in;
   tok_type                 tokn_ff;
   logic [NUM_W-1:0]        num_ff;
   tok_type                 toko_in;
   tok_type                 tokd_ff;
   tok_type                 dv_tok [0:PWM_BITS];
   dv_type                  dv_dat [0:PWM_BITS];
   dv_type                  dvo_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   tok_type last_tok;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_fwd_ff <= '0;
         coef_rev_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_QUAD_FWD:   coef_fwd_ff.a    <= csr_wdata;
            REG_LIN_FWD:    coef_fwd_ff.b    <= csr_wdata;
            REG_OFFSET_FWD: coef_fwd_ff.c    <= csr_wdata;
            REG_QUAD_REV:   coef_rev_ff.a    <= csr_wdata;
            REG_LIN_REV:    coef_rev_ff.b    <= csr_wdata;
            REG_OFFSET_REV: coef_rev_ff.c    <= csr_wdata;
            REG_MAXT_FWD:   coef_fwd_ff.tmax <= csr_wdata[MAXT_W-1:0];
            REG_MAXT_REV:   coef_rev_ff.tmax <= csr_wdata[MAXT_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   mtp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .req      (req_data),
      .coef_fwd (coef_fwd_ff),
      .coef_rev (coef_rev_ff),
      .tok_out  (front_tok),
      .disc_out (front_disc)
   );

   assign sq_tok[0]      = front_tok;
   assign sq_dat[0].rem  = '0;
   assign sq_dat[0].root = '0;
   assign sq_dat[0].dsh  = front_disc;

   for (genvar i = 0; i < SQ_ROOT_W; i++) begin : g_sqrt
      mtp_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (sq_tok[i]),
         .sq_in   (sq_dat[i]),
         .tok_out (sq_tok[i+1]),
         .sq_out  (sq_dat[i+1])
      );
   end

   always_comb begin
      if (sq_tok[SQ_ROOT_W].a_pos) begin
         n_in = $signed({2'b0, sq_dat[SQ_ROOT_W].root}) - NUM_W'(sq_tok[SQ_ROOT_W].b);
      end else begin
         n_in = $signed({2'b0, sq_dat[SQ_ROOT_W].root}) + NUM_W'(sq_tok[SQ_ROOT_W].b);
      end
      toko_in = tokn_ff;
      if (!tokn_ff.done
          && DIV_REM_W'(num_ff) >= DIV_REM_W'({tokn_ff.mag_a, 1'b0, {PWM_BITS{1'b0}}})) begin
         toko_in.done = 1'b1;
         toko_in.pwm  = PWM_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tokn_ff.valid <= 1'b0;
         tokd_ff.valid <= 1'b0;
      end else if (advance) begin
         tokn_ff <= sq_tok[SQ_ROOT_W];
         num_ff  <= n_in[NUM_W-1] ? NUM_W'(-n_in) : n_in;
         tokd_ff <= toko_in;
         dvo_ff  <= '{rem: DIV_REM_W'(num_ff), quo: '0};
      end
   end

   assign dv_tok[0] = tokd_ff;
   assign dv_dat[0] = dvo_ff;

   for (genvar k = 0; k < PWM_BITS; k++) begin : g_div
      mtp_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (dv_tok[k]),
         .dv_in   (dv_dat[k]),
         .tok_out (dv_tok[k+1]),
         .dv_out  (dv_dat[k+1])
      );
   end

   assign last_tok = dv_tok[PWM_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff        <= last_tok.valid;
         rsp_ff.thrust_out   <= last_tok.mode ? '0 : last_tok.thrust;
         rsp_ff.pwm_out      <= last_tok.done ? last_tok.pwm : dv_dat[PWM_BITS].quo;
         rsp_ff.domain_error <= last_tok.err;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> tb/motor_thrust_pwm_converter_top_tb.sv
// ----------------------------------------------------------------------------
// Motor thrust PWM converter testbench
// Sends a directed table of items and register writes, then random curve
// coefficients, thrust limits and items under several settings. Each result is
// checked against its table value or an exact integer predictor of both conversion modes.
// ----------------------------------------------------------------------------
module motor_thrust_pwm_converter_top_tb
   import mtp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic MODE_TO_THRUST = 1'b0;
   localparam logic MODE_TO_PWM    = 1'b1;
   localparam logic DIR_FWD        = 1'b1;
   localparam logic DIR_REV        = 1'b0;
   localparam int   DRAIN_CYCLES   = 64;

   typedef struct {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] wdata;
      req_type              req;
      bit                   known;
      rsp_type              rsp;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   logic [31:0] curve_regs [8];
   rsp_type     pending_rsp [$];
   int          fail_count = 0;
   bit          sender_gaps = 1'b1;

   motor_thrust_pwm_converter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_type convert_thrust(req_type r);
      rsp_type                  o;
      int                       sel;
      logic signed [31:0]       a, b, c;
      longint                   la, lb, lc, tmax, t, p, s, q, dd, nn, ma, qq;
      logic signed [127:0]      wa, wb, wd, disc;
      logic [127:0]             cand, root;
      o = '0;
      sel = (r.direction == DIR_FWD) ? 0 : 3;
      a = curve_regs[sel];
      b = curve_regs[sel + 1];
      c = curve_regs[sel + 2];
      la = a;
      lb = b;
      lc = c;
      tmax = {32'b0, curve_regs[(r.direction == DIR_FWD) ? 6 : 7]};
      if (r.mode == MODE_TO_THRUST) begin
         if (r.pwm_in != 0) begin
            p = {56'b0, r.pwm_in};
            s = la * p * p + lb * p + lc;
            q = s >>> 12;
            if (q > 64'sd8388607) q = 64'sd8388607;
            if (q < -64'sd8388608) q = -64'sd8388608;
            o.thrust_out = q[23:0];
         end
      end else begin
         t = {{40{r.thrust_in[23]}}, r.thrust_in};
         if (t <= 0) begin
            o.pwm_out = '0;
         end else if (t >= tmax) begin
            o.pwm_out = PWM_MAX;
         end else if (la == 0) begin
            o.domain_error = 1'b1;
         end else begin
            dd = t * 4096 - lc;
            wa = la;
            wb = lb;
            wd = dd;
            disc = 4 * wa * wd + wb * wb;
            if (disc < 0) begin
               o.domain_error = 1'b1;
            end else begin
               root = '0;
               for (int bit_i = 40; bit_i >= 0; bit_i--) begin
                  cand = root | (128'd1 << bit_i);
                  if (cand * cand <= $unsigned(disc)) root = cand;
               end
               nn = (la > 0) ? longint'(root[63:0]) - lb : longint'(root[63:0]) + lb;
               if (nn < 0) nn = -nn;
               ma = (la < 0) ? -la : la;
               qq = nn / (2 * ma);
               o.pwm_out = (qq > 255) ? PWM_MAX : qq[7:0];
            end
         end
      end
      return o;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!sender_gaps || roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < 6) curve_regs[idx] = value;
      else if (idx < 8) curve_regs[idx] = value & 32'h007F_FFFF;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(input req_type r, input bit known, input rsp_type exp_rsp);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(known ? exp_rsp : convert_thrust(r));
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic req_type random_item(longint tmax_hint);
      req_type r;
      int      roll;
      r.mode      = $urandom_range(0, 1);
      r.direction = $urandom_range(0, 1);
      r.pwm_in    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
      roll = $urandom_range(0, 9);
      if (roll < 6 && tmax_hint > 0) r.thrust_in = 24'($urandom_range(1, tmax_hint[31:0]));
      else if (roll < 8) r.thrust_in = 24'($urandom);
      else r.thrust_in = 24'($urandom_range(0, 512)) - 24'd256;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("Unexpected item: thrust_out %0d pwm_out %0d domain_error %0d",
                   rsp_data.thrust_out, rsp_data.pwm_out, rsp_data.domain_error);
            fail_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.thrust_out !== exp_rsp.thrust_out) begin
               $error("thrust_out expected %0d got %0d", exp_rsp.thrust_out,
                      rsp_data.thrust_out);
               fail_count++;
            end
            if (rsp_data.pwm_out !== exp_rsp.pwm_out) begin
               $error("pwm_out expected %0d got %0d", exp_rsp.pwm_out, rsp_data.pwm_out);
               fail_count++;
            end
            if (rsp_data.domain_error !== exp_rsp.domain_error) begin
               $error("domain_error expected %0d got %0d", exp_rsp.domain_error,
                      rsp_data.domain_error);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int stall_pct;
      forever begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 10;
            2: stall_pct = 40;
            default: stall_pct = 80;
         endcase
         repeat ($urandom_range(20, 200)) begin
            @(negedge clock);
            if ($urandom_range(0, 99) < stall_pct)
               rsp_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b1;
            else
               rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      plan_row_type plan [$];
      plan_row_type row;
      req_type      r;
      longint       hint;
      int           style;

      for (int i = 0; i < 8; i++) curve_regs[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      plan = '{
         '{0, '0, '0, '{MODE_TO_THRUST, DIR_FWD, 8'd0, 24'sd0}, 1, '{24'sd0, 8'd0, 1'b0}},
         '{0, '0, '0, '{MODE_TO_THRUST, DIR_REV, 8'd255, 24'sd0}, 1, '{24'sd0, 8'd0, 1'b0}},
         '{0, '0, '0, '{MODE_TO_PWM, DIR_FWD, 8'd0, 24'h800000}, 1, '{24'sd0, 8'd0, 1'b0}},
         '{0, '0, '0, '{MODE_TO_PWM, DIR_REV, 8'd0, 24'sd0}, 1, '{24'sd0, 8'd0, 1'b0}},
         '{0, '0, '0, '{MODE_TO_PWM, DIR_FWD, 8'd0, 24'h7FFFFF}, 1, '{24'sd0, 8'd255, 1'b0}},
         '{1, REG_MAXT_FWD, 32'hFFFF_FFFF, '0, 0, '0},
         '{1, REG_MAXT_REV, 32'h007F_FFFF, '0, 0, '0},
         '{1, 4'd9, 32'h1234_5678, '0, 0, '0},
         '{0, '0, '0, '{MODE_TO_PWM, DIR_FWD, 8'd0, 24'sd100}, 1, '{24'sd0, 8'd0, 1'b1}},
         '{0, '0, '0, '{MODE_TO_PWM, DIR_REV, 8'd0, 24'sd1}, 1, '{24'sd0, 8'd0, 1'b1}},
         '{1, REG_QUAD_FWD, 32'h7FFF_FFFF, '0, 0, '0},
         '{1, REG_LIN_FWD, 32'h8000_0000, '0, 0, '0},
         '{1, REG_OFFSET_FWD, 32'h7FFF_FFFF, '0, 0, '0},
         '{0, '0, '0, '{MODE_TO_THRUST, DIR_FWD, 8'd255, 24'sd0}, 1, '{24'h7FFFFF, 8'd0, 1'b0}},
         '{0, '0, '0, '{MODE_TO_THRUST, DIR_FWD, 8'd1, 24'sd0}, 0, '0},
         '{0, '0, '0, '{MODE_TO_PWM, DIR_FWD, 8'd0, 24'h7FFFFE}, 0, '0},
         '{1, REG_QUAD_REV, 32'h8000_0000, '0, 0, '0},
         '{1, REG_LIN_REV, 32'h7FFF_FFFF, '0, 0, '0},
         '{1, REG_OFFSET_REV, 32'h8000_0000, '0, 0, '0},
         '{0, '0, '0, '{MODE_TO_THRUST, DIR_REV, 8'd255, 24'sd0}, 1, '{24'h800000, 8'd0, 1'b0}},
         '{0, '0, '0, '{MODE_TO_PWM, DIR_REV, 8'd0, 24'sd1}, 0, '0},
         '{0, '0, '0, '{MODE_TO_PWM, DIR_REV, 8'd0, 24'h7FFFFE}, 0, '0},
         '{1, REG_QUAD_FWD, 32'h0010_0000, '0, 0, '0},
         '{1, REG_LIN_FWD, 32'h0000_0000, '0, 0, '0},
         '{1, REG_OFFSET_FWD, 32'h0000_0000, '0, 0, '0},
         '{1, REG_MAXT_FWD, 32'h0000_6400, '0, 0, '0},
         '{0, '0, '0, '{MODE_TO_PWM, DIR_FWD, 8'd0, 24'sd256}, 1, '{24'sd0, 8'd1, 1'b0}},
         '{0, '0, '0, '{MODE_TO_THRUST, DIR_FWD, 8'd16, 24'sd0}, 1, '{24'sd65536, 8'd0, 1'b0}},
         '{0, '0, '0, '{MODE_TO_PWM, DIR_FWD, 8'd0, 24'sd25599}, 0, '0},
         '{0, '0, '0, '{MODE_TO_PWM, DIR_FWD, 8'd0, 24'sd25600}, 1, '{24'sd0, 8'd255, 1'b0}},
         '{0, '0, '0, '{MODE_TO_THRUST, DIR_FWD, 8'd255, 24'sd0}, 0, '0}
      };

      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_csr) begin
            wait_idle();
            write_reg(row.idx, row.wdata);
         end else begin
            send_item(row.req, row.known, row.rsp);
         end
      end

      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         style = (phase == 7) ? 3 : $urandom_range(0, 3);
         for (int d = 0; d < 2; d++) begin
            case (style)
               0: begin
                  write_reg(d ? REG_QUAD_REV : REG_QUAD_FWD, $urandom_range(1, 40000));
                  write_reg(d ? REG_LIN_REV : REG_LIN_FWD,
                            32'($urandom_range(0, 1 << 22)) - 32'(1 << 21));
                  write_reg(d ? REG_OFFSET_REV : REG_OFFSET_FWD,
                            32'($urandom_range(0, 1 << 26)) - 32'(1 << 25));
               end
               1: begin
                  write_reg(d ? REG_QUAD_REV : REG_QUAD_FWD,
                            -32'($urandom_range(1, 40000)));
                  write_reg(d ? REG_LIN_REV : REG_LIN_FWD, $urandom_range(0, 1 << 24));
                  write_reg(d ? REG_OFFSET_REV : REG_OFFSET_FWD, $urandom);
               end
               2: begin
                  write_reg(d ? REG_QUAD_REV : REG_QUAD_FWD, $urandom);
                  write_reg(d ? REG_LIN_REV : REG_LIN_FWD, $urandom);
                  write_reg(d ? REG_OFFSET_REV : REG_OFFSET_FWD, $urandom);
               end
               default: begin
                  write_reg(d ? REG_QUAD_REV : REG_QUAD_FWD, d ? 32'h8000_0000 : 32'h7FFF_FFFF);
                  write_reg(d ? REG_LIN_REV : REG_LIN_FWD, d ? 32'h7FFF_FFFF : 32'h8000_0000);
                  write_reg(d ? REG_OFFSET_REV : REG_OFFSET_FWD, 32'h0000_0000);
               end
            endcase
            write_reg(d ? REG_MAXT_REV : REG_MAXT_FWD,
                      (style == 3) ? 32'hFFFF_FFFF : $urandom_range(256, 1 << 20));
         end
         hint = curve_regs[6] > curve_regs[7] ? curve_regs[6] : curve_regs[7];
         sender_gaps = (phase % 3 != 1);
         repeat (75) begin
            r = random_item(hint + 64);
            send_item(r, 0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/mtp_pkg.sv
rtl/mtp_front.sv
rtl/mtp_sqrt_cell.sv
rtl/mtp_div_cell.sv
rtl/motor_thrust_pwm_converter_top.sv
tb/motor_thrust_pwm_converter_top_tb.sv
